FILE: rtl/tbwe_pkg.sv
// shared types, constants and the wave table of the tape bit waveform encoder
`default_nettype none

package tbwe_pkg;

    localparam int MAX_BIT_PERIOD = 64;
    localparam int MIN_BIT_PERIOD = 2;
    localparam int ANGLE_STEPS    = 360;
    localparam int BITS_PER_BYTE  = 8;

    localparam int PERIOD_W   = 7;
    localparam int INDEX_W    = 6;
    localparam int COUNT_W    = 4;
    localparam int DEG_W      = 9;
    localparam int PRODUCT_W  = 15;
    localparam int DIV_STEPS  = DEG_W;
    localparam int DIV_CNT_W  = 4;
    localparam int CFG_DATA_W = PERIOD_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 7'd20;
    localparam logic [PERIOD_W-1:0] PERIOD_LOW       = PERIOD_W'(MIN_BIT_PERIOD);
    localparam logic [PERIOD_W-1:0] PERIOD_HIGH      = PERIOD_W'(MAX_BIT_PERIOD);

    localparam logic [7:0] SQUARE_HIGH = 8'd235;
    localparam logic [7:0] SQUARE_LOW  = 8'd20;

    // floor(x / 5) == (x * 3277) >> 14 for x below 16384
    localparam int                RECIP5_SHIFT = 14;
    localparam logic [11:0]       RECIP5       = 12'd3277;
    localparam logic signed [11:0] BOOST_BIAS  = 12'sd640;
    localparam logic signed [11:0] BOOST_GAIN  = 12'sd6;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_PERIOD  = 1'b0,
        REG_SQUARE_MODE = 1'b1
    } cfg_reg_t;

    // entry 0 holds the live encoder state
    localparam int STATE_DEPTH = 2;
    localparam int STATE_AW    = $clog2(STATE_DEPTH);

    typedef struct packed {
        logic [7:0]         shift_store;
        logic [COUNT_W-1:0] bits_left;
        logic [INDEX_W-1:0] sample_index;
    } enc_state_t;

    localparam int STATE_W = $bits(enc_state_t);

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] sample;
        logic       sample_valid;
        logic       byte_done;
        logic       load_refused;
    } result_t;

    localparam logic [6:0] QUARTER_WAVE [0:90] = '{
        7'd0,  7'd1,  7'd3,  7'd5,  7'd6,  7'd8,  7'd10, 7'd12, 7'd13, 7'd15,
        7'd17, 7'd19, 7'd20, 7'd22, 7'd24, 7'd25, 7'd27, 7'd29, 7'd30, 7'd32,
        7'd34, 7'd35, 7'd37, 7'd39, 7'd40, 7'd42, 7'd43, 7'd45, 7'd46, 7'd48,
        7'd49, 7'd51, 7'd52, 7'd54, 7'd55, 7'd57, 7'd58, 7'd60, 7'd61, 7'd62,
        7'd64, 7'd65, 7'd66, 7'd68, 7'd69, 7'd70, 7'd71, 7'd73, 7'd74, 7'd75,
        7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82, 7'd83, 7'd84, 7'd85,
        7'd86, 7'd87, 7'd88, 7'd89, 7'd89, 7'd90, 7'd91, 7'd92, 7'd92, 7'd93,
        7'd93, 7'd94, 7'd95, 7'd95, 7'd96, 7'd96, 7'd97, 7'd97, 7'd97, 7'd98,
        7'd98, 7'd98, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd100
    };

    // wave value in hundredths for an angle of 0..359 degrees
    function automatic logic signed [7:0] wave_value(input logic [DEG_W-1:0] deg);
        logic [DEG_W-1:0] d;
        logic [6:0]       mag;
        logic             neg;
        begin
            d = (deg > 9'd359) ? 9'd359 : deg;
            if (d <= 9'd90)
            begin
                mag = QUARTER_WAVE[d[6:0]];
                neg = 1'b1;
            end
            else if (d <= 9'd180)
            begin
                mag = (d == 9'd150) ? 7'd50 : QUARTER_WAVE[7'(9'd180 - d)];
                neg = 1'b1;
            end
            else if (d <= 9'd270)
            begin
                mag = QUARTER_WAVE[7'(d - 9'd180)];
                neg = 1'b0;
            end
            else
            begin
                mag = (d == 9'd330) ? 7'd50 : QUARTER_WAVE[7'(9'd360 - d)];
                neg = 1'b0;
            end
            wave_value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tape_bit_waveform_encoder_top.sv
// top level of the tape bit waveform encoder
//
// item channel: item_valid / item_stall carry a request {action, data_byte}.
// a load request starts a byte (msb first); it is refused while a byte is
// still sending. a tick request yields the next audio sample of the byte,
// or silence (sample 0) when idle. every request gives one result on the
// result channel (result_valid / result_stall).
// the encoder state lives in a small synchronous ram that is read, updated
// and written back once per request.
// a load, an idle tick or a square-mode tick passes through S_CALC and
// S_FINISH, a sine-mode tick through S_CALC, S_DIV and S_FINISH; the sine
// phase angle floor(i*360/n) comes from a radix-2 divider that retires
// one quotient bit per cycle. one request is worked at a time; the next
// is taken once the current result sits in the output register, so a new
// request is not taken before the current one is through.
// a held result waits in the output register while the next request is
// already taken; a finished request waits for that register to free up.
// reset: bit_period is 20, square_mode 0, the encoder is idle, no result.
// configuration writes are taken on any cycle with cfg_we high.
`default_nettype none

module tape_bit_waveform_encoder_top
    import tbwe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_FINISH
    } fsm_t;

    fsm_t                  fsm_reg, fsm_next;
    item_t                 item_reg, item_next;
    result_t               res_reg, res_next;
    enc_state_t            upd_reg, upd_next;
    logic                  sine_reg, sine_next;
    logic                  one_reg, one_next;
    logic [PERIOD_W-1:0]   bit_period_reg, bit_period_next;
    logic                  square_mode_reg, square_mode_next;
    logic                  state_ok_reg, state_ok_next;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg, result_next;

    logic [PERIOD_W-1:0]   div_rem_reg, div_rem_next;
    logic [DEG_W-1:0]      div_dvd_reg, div_dvd_next;
    logic [DEG_W-1:0]      div_quo_reg, div_quo_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [PERIOD_W-1:0]   div_n_reg, div_n_next;

    logic                  ram_we;
    enc_state_t            ram_rdata;
    logic [STATE_W-1:0]    ram_rdata_raw;
    enc_state_t            cur;

    logic [PERIOD_W-1:0]   period;
    logic [PERIOD_W-1:0]   n;
    logic [INDEX_W-1:0]    idx;
    logic                  last;
    logic [PRODUCT_W-1:0]  phase;
    logic [PERIOD_W:0]     trial;
    logic                  out_free;

    logic signed [7:0]     wv;
    logic signed [11:0]    boost_num;
    logic [23:0]           boost_prod;
    logic [7:0]            sine_sample;

    tbwe_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (STATE_AW'(0)),
        .wdata (upd_reg),
        .raddr (STATE_AW'(0)),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = enc_state_t'(ram_rdata_raw);
    // an unwritten state entry reads as reset (idle)
    assign cur = state_ok_reg ? ram_rdata : '0;

    assign out_free     = !result_valid_reg || !result_stall;
    assign ram_we       = (fsm_reg == S_FINISH) && out_free;
    assign item_stall   = (fsm_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // bit geometry of the current bit
    always_comb
    begin
        if (bit_period_reg < PERIOD_LOW)
        begin
            period = PERIOD_LOW;
        end
        else if (bit_period_reg > PERIOD_HIGH)
        begin
            period = PERIOD_HIGH;
        end
        else
        begin
            period = bit_period_reg;
        end
        n     = cur.shift_store[7] ? period : (period >> 1);
        idx   = ({1'b0, cur.sample_index} >= n) ? INDEX_W'(n - 7'd1) : cur.sample_index;
        last  = ({1'b0, idx} + 7'd1) >= n;
        phase = PRODUCT_W'({9'd0, idx} * PRODUCT_W'(ANGLE_STEPS));
    end

    // sine sample from the divider quotient
    always_comb
    begin
        wv          = wave_value(div_quo_reg);
        boost_num   = BOOST_BIAS + ($signed({{4{wv[7]}}, wv}) * BOOST_GAIN);
        boost_prod  = {13'd0, boost_num[10:0]} * {12'd0, RECIP5};
        sine_sample = one_reg ? boost_prod[RECIP5_SHIFT+7:RECIP5_SHIFT]
                              : {~wv[7], wv[6:0]};
    end

    assign trial = {div_rem_reg, div_dvd_reg[DEG_W-1]};

    always_comb
    begin
        fsm_next          = fsm_reg;
        item_next         = item_reg;
        res_next          = res_reg;
        upd_next          = upd_reg;
        sine_next         = sine_reg;
        one_next          = one_reg;
        bit_period_next   = bit_period_reg;
        square_mode_next  = square_mode_reg;
        state_ok_next     = state_ok_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        div_rem_next      = div_rem_reg;
        div_dvd_next      = div_dvd_reg;
        div_quo_next      = div_quo_reg;
        div_cnt_next      = div_cnt_reg;
        div_n_next        = div_n_reg;

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BIT_PERIOD:  bit_period_next  = cfg_data;
                REG_SQUARE_MODE: square_mode_next = cfg_data[0];
                default:         ;
            endcase
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (fsm_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    fsm_next  = S_CALC;
                end
            end
            S_CALC:
            begin
                res_next  = '0;
                upd_next  = cur;
                sine_next = 1'b0;
                one_next  = cur.shift_store[7];
                fsm_next  = S_FINISH;
                if (item_reg.action == ACT_LOAD)
                begin
                    if (cur.bits_left != '0)
                    begin
                        res_next.load_refused = 1'b1;
                    end
                    else
                    begin
                        upd_next.shift_store  = item_reg.data_byte;
                        upd_next.bits_left    = COUNT_W'(BITS_PER_BYTE);
                        upd_next.sample_index = '0;
                    end
                end
                else if (cur.bits_left != '0)
                begin
                    res_next.sample_valid = 1'b1;
                    if (square_mode_reg)
                    begin
                        res_next.sample = ({1'b0, idx} < (n >> 1)) ? SQUARE_HIGH : SQUARE_LOW;
                    end
                    else
                    begin
                        // quotient < 512 so the top dividend bits start below n
                        sine_next    = 1'b1;
                        div_rem_next = {1'b0, phase[PRODUCT_W-1:DEG_W]};
                        div_dvd_next = phase[DEG_W-1:0];
                        div_quo_next = '0;
                        div_cnt_next = DIV_CNT_W'(DIV_STEPS);
                        div_n_next   = n;
                        fsm_next     = S_DIV;
                    end
                    if (last)
                    begin
                        upd_next.sample_index = '0;
                        upd_next.shift_store  = {cur.shift_store[6:0], 1'b0};
                        upd_next.bits_left    = cur.bits_left - 4'd1;
                        res_next.byte_done    = (cur.bits_left == 4'd1);
                    end
                    else
                    begin
                        upd_next.sample_index = idx + 6'd1;
                    end
                end
            end
            S_DIV:
            begin
                if (trial >= {1'b0, div_n_reg})
                begin
                    div_rem_next = PERIOD_W'(trial - {1'b0, div_n_reg});
                    div_quo_next = {div_quo_reg[DEG_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = trial[PERIOD_W-1:0];
                    div_quo_next = {div_quo_reg[DEG_W-2:0], 1'b0};
                end
                div_dvd_next = {div_dvd_reg[DEG_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg - 4'd1;
                if (div_cnt_reg == 4'd1)
                begin
                    fsm_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    result_next = res_reg;
                    if (sine_reg)
                    begin
                        result_next.sample = sine_sample;
                    end
                    result_valid_next = 1'b1;
                    state_ok_next     = 1'b1;
                    fsm_next          = S_IDLE;
                end
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg          <= S_IDLE;
            bit_period_reg   <= BIT_PERIOD_RESET;
            square_mode_reg  <= 1'b0;
            state_ok_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            fsm_reg          <= fsm_next;
            bit_period_reg   <= bit_period_next;
            square_mode_reg  <= square_mode_next;
            state_ok_reg     <= state_ok_next;
            result_valid_reg <= result_valid_next;
            div_cnt_reg      <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        res_reg     <= res_next;
        upd_reg     <= upd_next;
        sine_reg    <= sine_next;
        one_reg     <= one_next;
        result_reg  <= result_next;
        div_rem_reg <= div_rem_next;
        div_dvd_reg <= div_dvd_next;
        div_quo_reg <= div_quo_next;
        div_n_reg   <= div_n_next;
    end

endmodule

`default_nettype wire

FILE: rtl/tbwe_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module tbwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// self-checking testbench for the tape bit waveform encoder top level
`timescale 1ns / 1ps

module tb_top;
    import tbwe_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 600;
    localparam int IDLE_PCT     = 17;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [7:0] LEVEL_HIGH = 8'd235;
    localparam logic [7:0] LEVEL_LOW  = 8'd20;

    // trunc(100*sin(d)) for d = 0..90 degrees (49 at d = 30)
    localparam logic [6:0] SINE_MAG [0:90] = '{
        7'd0,  7'd1,  7'd3,  7'd5,  7'd6,  7'd8,  7'd10, 7'd12, 7'd13, 7'd15,
        7'd17, 7'd19, 7'd20, 7'd22, 7'd24, 7'd25, 7'd27, 7'd29, 7'd30, 7'd32,
        7'd34, 7'd35, 7'd37, 7'd39, 7'd40, 7'd42, 7'd43, 7'd45, 7'd46, 7'd48,
        7'd49, 7'd51, 7'd52, 7'd54, 7'd55, 7'd57, 7'd58, 7'd60, 7'd61, 7'd62,
        7'd64, 7'd65, 7'd66, 7'd68, 7'd69, 7'd70, 7'd71, 7'd73, 7'd74, 7'd75,
        7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82, 7'd83, 7'd84, 7'd85,
        7'd86, 7'd87, 7'd88, 7'd89, 7'd89, 7'd90, 7'd91, 7'd92, 7'd92, 7'd93,
        7'd93, 7'd94, 7'd95, 7'd95, 7'd96, 7'd96, 7'd97, 7'd97, 7'd97, 7'd98,
        7'd98, 7'd98, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd100
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // stimulus and scoreboard
    item_t   request_queue [$];
    result_t predicted_outputs [$];
    result_t predicted;
    result_t want;
    logic    req_taken = 1'b0;
    logic    quiet = 1'b0;
    logic    hold_trigger = 1'b0;
    int      hold_left = 0;
    int      errors = 0;
    int      cycles = 0;
    int      queued = 0;

    // encoder copy of the predictor
    logic [PERIOD_W-1:0] cur_period;
    logic                cur_square;
    logic [7:0]          enc_shift;
    logic [COUNT_W-1:0]  enc_bits_left;
    logic [INDEX_W-1:0]  enc_index;

    int n_loads = 0, n_refused = 0, n_samples = 0, n_silent = 0, n_bytes = 0, n_writes = 0;

    tape_bit_waveform_encoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int sine_hundredths(input int deg);
        if (deg <= 90)
            return -int'(SINE_MAG[deg]);
        if (deg <= 180)
            return (deg == 150) ? -50 : -int'(SINE_MAG[180 - deg]);
        if (deg <= 270)
            return int'(SINE_MAG[deg - 180]);
        return (deg == 330) ? 50 : int'(SINE_MAG[360 - deg]);
    endfunction

    task automatic encode_request(input item_t req, output result_t res);
        int   eff;
        int   n;
        int   idx;
        int   v;
        logic one;
        res = '0;
        if (req.action == ACT_LOAD)
        begin
            if (enc_bits_left != 0)
                res.load_refused = 1'b1;
            else
            begin
                enc_shift     = req.data_byte;
                enc_bits_left = COUNT_W'(BITS_PER_BYTE);
                enc_index     = '0;
            end
        end
        else if (enc_bits_left != 0)
        begin
            eff = cur_period;
            if (eff < MIN_BIT_PERIOD)
                eff = MIN_BIT_PERIOD;
            if (eff > MAX_BIT_PERIOD)
                eff = MAX_BIT_PERIOD;
            one = enc_shift[7];
            n   = one ? eff : eff / 2;
            idx = enc_index;
            // period shrunk under a running bit: finish the bit now
            if (idx >= n)
                idx = n - 1;
            if (cur_square)
                res.sample = (idx < n / 2) ? LEVEL_HIGH : LEVEL_LOW;
            else
            begin
                v = sine_hundredths((idx * 360) / n);
                res.sample = one ? 8'((6 * v + 640) / 5) : 8'(v + 128);
            end
            res.sample_valid = 1'b1;
            if (idx + 1 >= n)
            begin
                enc_index     = '0;
                enc_shift     = {enc_shift[6:0], 1'b0};
                enc_bits_left = enc_bits_left - 1'b1;
                res.byte_done = (enc_bits_left == 0);
            end
            else
                enc_index = INDEX_W'(idx + 1);
        end
    endtask

    task automatic check_field(input string what, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || req_taken))
        begin
            if (request_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                item       <= request_queue.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // accepted requests go through the predictor
    always @(posedge clk)
    begin
        req_taken <= rst_n && item_valid && !item_stall;
        if (rst_n && item_valid && !item_stall)
        begin
            encode_request(item, predicted);
            predicted_outputs.push_back(predicted);
            if (item.action == ACT_LOAD)
                n_loads++;
            if (predicted.load_refused)
                n_refused++;
            if (predicted.sample_valid)
                n_samples++;
            else if (item.action == ACT_TICK)
                n_silent++;
            if (predicted.byte_done)
                n_bytes++;
        end
    end

    // output stall, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_trigger)
        begin
            hold_left    = HOLD_CYCLES;
            hold_trigger = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_outputs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual sample %0d flags %b%b%b",
                         $time, result.sample, result.sample_valid, result.byte_done,
                         result.load_refused);
            end
            else
            begin
                want = predicted_outputs.pop_front();
                check_field("sample", want.sample, result.sample);
                check_field("sample_valid", want.sample_valid, result.sample_valid);
                check_field("byte_done", want.byte_done, result.byte_done);
                check_field("load_refused", want.load_refused, result.load_refused);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, predicted_outputs.size());
            $display("[tape_bit_waveform_encoder_top] ERROR");
            $finish;
        end
    end

    task automatic queue_req(input logic act, input logic [7:0] data);
        item_t t;
        t.action    = act;
        t.data_byte = data;
        request_queue.push_back(t);
        queued++;
    endtask

    task automatic write_reg(input cfg_reg_t which, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= CFG_DATA_W'(value);
        if (which == REG_BIT_PERIOD)
            cur_period = PERIOD_W'(value);
        else
            cur_square = value[0];
        n_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained;
        while (request_queue.size() != 0 || item_valid || predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // mostly whole bytes: a load and about as many ticks as the byte lasts
    task automatic fill_phase(input int budget);
        int         left;
        int         eff;
        int         ones;
        int         ticks;
        int         k;
        int         refuse_at;
        logic [7:0] b;
        left = budget;
        while (left > 0)
        begin
            if ($urandom_range(99) < 15)
            begin
                queue_req(1'($urandom_range(1)), 8'($urandom_range(255)));
                left--;
            end
            else
            begin
                b   = 8'($urandom_range(255));
                eff = (cur_period < MIN_BIT_PERIOD) ? MIN_BIT_PERIOD :
                      (cur_period > MAX_BIT_PERIOD) ? MAX_BIT_PERIOD : int'(cur_period);
                ones  = $countones(b);
                ticks = ones * eff + (8 - ones) * (eff / 2) + $urandom_range(3) - 1;
                refuse_at = ($urandom_range(3) == 0) ? $urandom_range(ticks - 1) : -1;
                queue_req(ACT_LOAD, b);
                left--;
                for (k = 0; k < ticks && left > 0; k++)
                begin
                    if (k == refuse_at)
                        queue_req(ACT_LOAD, 8'($urandom_range(255)));
                    queue_req(ACT_TICK, 8'($urandom_range(255)));
                    left--;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        int start;
        int phase;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_BIT_PERIOD;
        cfg_data     = '0;
        cur_period    = BIT_PERIOD_RESET;
        cur_square    = 1'b0;
        enc_shift     = '0;
        enc_bits_left = '0;
        enc_index     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset settings: silence, a load, two refused loads, a few samples
        queue_req(ACT_TICK, 8'hFF);
        queue_req(ACT_LOAD, 8'h80);
        queue_req(ACT_LOAD, 8'hFF);
        queue_req(ACT_LOAD, 8'h00);
        repeat (3) queue_req(ACT_TICK, 8'h00);
        wait_drained;
        // period below range while the one bit is past the new length
        write_reg(REG_BIT_PERIOD, 1);
        repeat (9) queue_req(ACT_TICK, 8'h5A);
        wait_drained;
        write_reg(REG_SQUARE_MODE, 1);
        write_reg(REG_BIT_PERIOD, 127);
        queue_req(ACT_LOAD, 8'hFF);
        repeat (3) queue_req(ACT_TICK, 8'hA5);
        wait_drained;

        start = queued;
        phase = 0;
        while (queued - start < RANDOM_ITEMS)
        begin
            case (phase)
                0: begin write_reg(REG_BIT_PERIOD, 127); write_reg(REG_SQUARE_MODE, 0); end
                1: begin write_reg(REG_BIT_PERIOD, 64);  write_reg(REG_SQUARE_MODE, 1); end
                2: begin write_reg(REG_BIT_PERIOD, 0);   write_reg(REG_SQUARE_MODE, 0); end
                3: write_reg(REG_BIT_PERIOD, 2);
                4: begin write_reg(REG_BIT_PERIOD, 65);  write_reg(REG_SQUARE_MODE, 1); end
                5: begin write_reg(REG_BIT_PERIOD, 3);   write_reg(REG_SQUARE_MODE, 0); end
                6: write_reg(REG_BIT_PERIOD, 20);
                default:
                begin
                    if ($urandom_range(9) < 7)
                        write_reg(REG_BIT_PERIOD, ($urandom_range(9) < 8) ? $urandom_range(2, 10) :
                                                  $urandom_range(127));
                    if ($urandom_range(1) == 1)
                        write_reg(REG_SQUARE_MODE, $urandom_range(1));
                end
            endcase
            if (phase == 3)
                hold_trigger = 1'b1;
            quiet = (phase == 5);
            fill_phase($urandom_range(40, 90));
            // sender pauses here until every result is back
            wait_drained;
            phase++;
        end
        quiet = 1'b0;

        wait_drained;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (predicted_outputs.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, predicted_outputs.size());
        end
        $display("covered %0d loads (%0d refused), %0d samples, %0d silent ticks, %0d bytes sent",
                 n_loads, n_refused, n_samples, n_silent, n_bytes);
        $display("over %0d register writes: periods 0 to 127, sine and square, one long output hold-off",
                 n_writes);
        if (errors == 0)
            $display("[tape_bit_waveform_encoder_top] OK");
        else
            $display("[tape_bit_waveform_encoder_top] ERROR");
        $finish;
    end

endmodule
